[src/gn3_pkg.sv]
// Shared types, constants and defaults for the 3D gradient noise unit.
package gn3_pkg;

  localparam int TableSizeDef = 256;
  localparam int FracBitsDef  = 16;

  localparam int COORD_W = 32;
  localparam int TIDX_W  = 8;
  localparam int TVAL_W  = 8;
  localparam int OUT_W   = 18;
  localparam int OUT_FRAC = 16;
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Gradient hash codes that pick x as the second term.
  localparam logic [3:0] GRAD_X_A = 4'd12;
  localparam logic [3:0] GRAD_X_B = 4'd14;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // Control part of one item as it moves from front to back.
  typedef struct packed {
    op_e               op;
    logic [TIDX_W-1:0] idx;
    logic [TVAL_W-1:0] val;
  } ctl_t;

endpackage

[src/gn3_if.sv]
// Stream interfaces for the noise unit's input and result channels.
interface gn3_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [gn3_pkg::TIDX_W-1:0] table_index;
  logic [gn3_pkg::TVAL_W-1:0] table_value;
  logic signed [gn3_pkg::COORD_W-1:0] coord_x;
  logic signed [gn3_pkg::COORD_W-1:0] coord_y;
  logic signed [gn3_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, op, table_index, table_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, op, table_index, table_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gn3_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [gn3_pkg::OUT_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

[src/gn3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[src/gn3_front.sv]
// Front end: accepts beats, splits coordinates into cell and fraction, queues them.
module gn3_front #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  localparam int IdxW = $clog2(TABLE_SIZE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gn3_in_if.sink                in_if,
  output logic                  vld_o,
  input  logic                  pop_i,
  output gn3_pkg::ctl_t         ctl_o,
  output logic [IdxW-1:0]       cell_x_o,
  output logic [IdxW-1:0]       cell_y_o,
  output logic [IdxW-1:0]       cell_z_o,
  output logic [FRAC_BITS-1:0]  frac_x_o,
  output logic [FRAC_BITS-1:0]  frac_y_o,
  output logic [FRAC_BITS-1:0]  frac_z_o
);
  import gn3_pkg::*;

  localparam int EW = $bits(ctl_t) + 3 * IdxW + 3 * FRAC_BITS;

  logic [EW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  logic signed [COORD_W-1:0] fl_x, fl_y, fl_z;
  ctl_t          ctl_in;
  logic [EW-1:0] entry;

  // The arithmetic shift gives the floor; its low bits are the wrapped cell.
  assign fl_x = in_if.coord_x >>> FRAC_BITS;
  assign fl_y = in_if.coord_y >>> FRAC_BITS;
  assign fl_z = in_if.coord_z >>> FRAC_BITS;

  assign ctl_in.op  = op_e'(in_if.op);
  assign ctl_in.idx = in_if.table_index;
  assign ctl_in.val = in_if.table_value;

  assign entry = {ctl_in, fl_x[IdxW-1:0], fl_y[IdxW-1:0], fl_z[IdxW-1:0],
                  in_if.coord_x[FRAC_BITS-1:0], in_if.coord_y[FRAC_BITS-1:0],
                  in_if.coord_z[FRAC_BITS-1:0]};

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign vld_o       = (cnt_q != 2'd0);
  assign pop         = pop_i && vld_o;

  assign {ctl_o, cell_x_o, cell_y_o, cell_z_o, frac_x_o, frac_y_o, frac_z_o} = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

[src/gn3_back.sv]
// Back end: table lookups, fade curves, gradients and trilinear blend in a stalling pipeline.
module gn3_back #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  localparam int IdxW = $clog2(TABLE_SIZE)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  output logic                  pop_o,
  input  gn3_pkg::ctl_t         ctl_i,
  input  logic [IdxW-1:0]       cell_x_i,
  input  logic [IdxW-1:0]       cell_y_i,
  input  logic [IdxW-1:0]       cell_z_i,
  input  logic [FRAC_BITS-1:0]  frac_x_i,
  input  logic [FRAC_BITS-1:0]  frac_y_i,
  input  logic [FRAC_BITS-1:0]  frac_z_i,
  gn3_out_if.source             out_if
);
  import gn3_pkg::*;

  localparam int F   = FRAC_BITS;
  // A gradient dot reaches +2.0 exactly when two offsets of -1.0 are both negated.
  localparam int GW  = F + 3;
  localparam int PW  = F + 4;
  localparam int TW  = F + 1;
  localparam int RW  = GW + 9;
  localparam int NRAM = 14;
  localparam logic signed [GW-1:0] OneFx = {3'b001, {F{1'b0}}};
  localparam logic [PW-1:0] PolyC = {4'd10, {F{1'b0}}};
  localparam logic signed [RW-1:0] SatHi = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SatLo = RW'(OUT_MIN);

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [GW-1:0] dx, input logic signed [GW-1:0] dy,
      input logic signed [GW-1:0] dz);
    logic signed [GW-1:0] a, b;
    a = (h < 4'd8) ? dx : dy;
    b = (h < 4'd4) ? dy : ((h == GRAD_X_A || h == GRAD_X_B) ? dx : dz);
    if (h[0]) a = -a;
    if (h[1]) b = -b;
    return a + b;
  endfunction

  function automatic logic signed [GW-1:0] blend(input logic signed [GW-1:0] a,
      input logic signed [GW-1:0] b, input logic [TW-1:0] t);
    logic signed [GW:0]        diff;
    logic signed [GW+TW+1:0]   prod;
    diff = (GW+1)'(b) - (GW+1)'(a);
    prod = diff * $signed({1'b0, t});
    return a + GW'(prod >>> F);
  endfunction

  logic en;

  // Table copies: two for the x hash, four for the y hash, eight for the corner hashes.
  logic [IdxW-1:0]   rd_addr [NRAM];
  logic [TVAL_W-1:0] rd_data [NRAM];
  logic              wr_en   [NRAM];
  logic [IdxW-1:0]   wr_addr [NRAM];
  logic [TVAL_W-1:0] wr_data [NRAM];

  // Stage 1
  logic s1_vld_q;
  ctl_t s1_ctl_q;
  logic [IdxW-1:0]  s1_cy_q, s1_cz_q;
  logic [F-1:0]     s1_f_q  [3];
  logic [2*F-1:0]   s1_ff_q [3];
  // Stage 2
  logic s2_vld_q;
  ctl_t s2_ctl_q;
  logic [IdxW-1:0]  s2_cz_q;
  logic [F-1:0]     s2_f_q  [3];
  logic [2*F-1:0]   s2_cub_q [3];
  logic [PW-1:0]    s2_poly_q [3];
  // Stage 3
  logic s3_vld_q;
  logic [F-1:0]     s3_f_q  [3];
  logic [TW-1:0]    s3_t_q  [3];
  // Stage 4
  logic s4_vld_q;
  logic signed [GW-1:0] s4_g_q [8];
  logic [TW-1:0]    s4_t_q  [3];
  // Stage 5
  logic s5_vld_q;
  logic signed [GW-1:0] s5_x_q [4];
  logic [TW-1:0]    s5_v_q, s5_w_q;
  // Stage 6
  logic s6_vld_q;
  logic signed [GW-1:0] s6_y_q [2];
  logic [TW-1:0]    s6_w_q;
  // Output
  logic out_vld_q;
  logic signed [OUT_W-1:0] out_q;

  logic [F-1:0]     s0_f [3];
  logic [2*F-1:0]   s1_ff_d [3];
  logic [2*F-1:0]   s2_cub_d [3];
  logic [PW-1:0]    s2_poly_d [3];
  logic [2*F+2:0]   six_ff [3];
  logic [2*F+3:0]   fade_prod [3];
  logic [TW-1:0]    s3_t_d [3];
  logic [IdxW-1:0]  ha, hb, haa, hab, hba, hbb;
  logic signed [GW-1:0] dx0, dx1, dy0, dy1, dz0, dz1;
  logic signed [GW-1:0] s4_g_d [8];
  logic signed [GW-1:0] r_blend;
  logic signed [RW-1:0] r_wide, r_scaled;
  logic signed [OUT_W-1:0] out_d;

  assign en    = !out_vld_q || out_if.ready;
  assign pop_o = en && vld_i;

  assign s0_f[0] = frac_x_i;
  assign s0_f[1] = frac_y_i;
  assign s0_f[2] = frac_z_i;

  // Fade curve: squares, then cube and polynomial, then their product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_ff_d[i]   = s0_f[i] * s0_f[i];
      s2_cub_d[i]  = s1_ff_q[i][2*F-1:F] * s1_f_q[i];
      six_ff[i]    = (2*F+3)'(s1_ff_q[i]) * (2*F+3)'(6);
      s2_poly_d[i] = PolyC - PW'(PW'(s1_f_q[i]) * PW'(15)) + PW'(six_ff[i] >> F);
      fade_prod[i] = (2*F+4)'(s2_cub_q[i][2*F-1:F]) * (2*F+4)'(s2_poly_q[i]);
      s3_t_d[i]    = fade_prod[i][2*F:F];
    end
  end

  // Hash chain through the table copies.
  always_comb begin
    ha  = IdxW'(rd_data[0]) + s1_cy_q;
    hb  = IdxW'(rd_data[1]) + s1_cy_q;
    haa = IdxW'(rd_data[2]) + s2_cz_q;
    hab = IdxW'(rd_data[3]) + s2_cz_q;
    hba = IdxW'(rd_data[4]) + s2_cz_q;
    hbb = IdxW'(rd_data[5]) + s2_cz_q;
    rd_addr[0]  = cell_x_i;
    rd_addr[1]  = cell_x_i + IdxW'(1);
    rd_addr[2]  = ha;
    rd_addr[3]  = ha + IdxW'(1);
    rd_addr[4]  = hb;
    rd_addr[5]  = hb + IdxW'(1);
    rd_addr[6]  = haa;
    rd_addr[7]  = hba;
    rd_addr[8]  = hab;
    rd_addr[9]  = hbb;
    rd_addr[10] = haa + IdxW'(1);
    rd_addr[11] = hba + IdxW'(1);
    rd_addr[12] = hab + IdxW'(1);
    rd_addr[13] = hbb + IdxW'(1);
    // A load writes each copy as it passes the stage that reads that copy,
    // so items keep their order against table updates.
    for (int k = 0; k < NRAM; k++) begin
      if (k < 2) begin
        wr_en[k]   = en && vld_i && (ctl_i.op == OP_LOAD);
        wr_addr[k] = IdxW'(ctl_i.idx);
        wr_data[k] = ctl_i.val;
      end else if (k < 6) begin
        wr_en[k]   = en && s1_vld_q && (s1_ctl_q.op == OP_LOAD);
        wr_addr[k] = IdxW'(s1_ctl_q.idx);
        wr_data[k] = s1_ctl_q.val;
      end else begin
        wr_en[k]   = en && s2_vld_q && (s2_ctl_q.op == OP_LOAD);
        wr_addr[k] = IdxW'(s2_ctl_q.idx);
        wr_data[k] = s2_ctl_q.val;
      end
    end
  end

  for (genvar k = 0; k < NRAM; k++) begin : g_tbl
    gn3_ram #(
      .WIDTH (TVAL_W),
      .DEPTH (TABLE_SIZE)
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en[k]),
      .wr_addr_i (wr_addr[k]),
      .wr_data_i (wr_data[k]),
      .rd_en_i   (en),
      .rd_addr_i (rd_addr[k]),
      .rd_data_o (rd_data[k])
    );
  end

  // Gradient dots at the eight corners.
  always_comb begin
    dx0 = $signed({3'b000, s3_f_q[0]});
    dy0 = $signed({3'b000, s3_f_q[1]});
    dz0 = $signed({3'b000, s3_f_q[2]});
    dx1 = dx0 - OneFx;
    dy1 = dy0 - OneFx;
    dz1 = dz0 - OneFx;
    s4_g_d[0] = grad(rd_data[6][3:0],  dx0, dy0, dz0);
    s4_g_d[1] = grad(rd_data[7][3:0],  dx1, dy0, dz0);
    s4_g_d[2] = grad(rd_data[8][3:0],  dx0, dy1, dz0);
    s4_g_d[3] = grad(rd_data[9][3:0],  dx1, dy1, dz0);
    s4_g_d[4] = grad(rd_data[10][3:0], dx0, dy0, dz1);
    s4_g_d[5] = grad(rd_data[11][3:0], dx1, dy0, dz1);
    s4_g_d[6] = grad(rd_data[12][3:0], dx0, dy1, dz1);
    s4_g_d[7] = grad(rd_data[13][3:0], dx1, dy1, dz1);
  end

  // Last blend, rescale to sixteen fraction bits and saturate.
  assign r_blend = blend(s6_y_q[0], s6_y_q[1], s6_w_q);
  assign r_wide  = RW'(r_blend);
  if (FRAC_BITS > OUT_FRAC) begin : g_down
    assign r_scaled = r_wide >>> (FRAC_BITS - OUT_FRAC);
  end else begin : g_up
    assign r_scaled = r_wide <<< (OUT_FRAC - FRAC_BITS);
  end

  always_comb begin
    if (r_scaled > SatHi) begin
      out_d = OUT_W'(SatHi);
    end else if (r_scaled < SatLo) begin
      out_d = OUT_W'(SatLo);
    end else begin
      out_d = OUT_W'(r_scaled);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= vld_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q && (s2_ctl_q.op == OP_EVAL);
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      out_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctl_q <= ctl_i;
      s1_cy_q  <= cell_y_i;
      s1_cz_q  <= cell_z_i;
      s2_ctl_q <= s1_ctl_q;
      s2_cz_q  <= s1_cz_q;
      for (int i = 0; i < 3; i++) begin
        s1_f_q[i]    <= s0_f[i];
        s1_ff_q[i]   <= s1_ff_d[i];
        s2_f_q[i]    <= s1_f_q[i];
        s2_cub_q[i]  <= s2_cub_d[i];
        s2_poly_q[i] <= s2_poly_d[i];
        s3_f_q[i]    <= s2_f_q[i];
        s3_t_q[i]    <= s3_t_d[i];
        s4_t_q[i]    <= s3_t_q[i];
      end
      for (int j = 0; j < 8; j++) begin
        s4_g_q[j] <= s4_g_d[j];
      end
      for (int j = 0; j < 4; j++) begin
        s5_x_q[j] <= blend(s4_g_q[2*j], s4_g_q[2*j+1], s4_t_q[0]);
      end
      s5_v_q    <= s4_t_q[1];
      s5_w_q    <= s4_t_q[2];
      s6_y_q[0] <= blend(s5_x_q[0], s5_x_q[1], s5_v_q);
      s6_y_q[1] <= blend(s5_x_q[2], s5_x_q[3], s5_v_q);
      s6_w_q    <= s5_w_q;
      out_q     <= out_d;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.noise_value = out_q;

endmodule

[src/gradient_noise_3d_unit.sv]
// Top level of the 3D gradient noise unit: front end, queue and evaluation pipeline.
//
//   channel   direction  payload                                          beat
//   in_if     sink       op, table_index, table_value, coord_x/y/z        load or evaluate
//   out_if    source     noise_value (signed Q1.16, saturated)            one per evaluate
//
// One beat is taken per cycle while the queue has room; an evaluate beat passes through
// the queue, then six pipeline stages and the output register, before its result is valid.
// Load beats write the table copies in order with evaluates and give no result.
// Reset clears all valid state; the table is undefined until loaded.
// A stalled result halts the pipeline; the queue absorbs up to two further beats.
// TABLE_SIZE must be a power of two.
module gradient_noise_3d_unit #(
  parameter int TABLE_SIZE = gn3_pkg::TableSizeDef,
  parameter int FRAC_BITS  = gn3_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gn3_in_if.sink     in_if,
  gn3_out_if.source  out_if
);
  import gn3_pkg::*;

  localparam int IdxW = $clog2(TABLE_SIZE);

  logic                 q_vld, q_pop;
  ctl_t                 q_ctl;
  logic [IdxW-1:0]      q_cx, q_cy, q_cz;
  logic [FRAC_BITS-1:0] q_fx, q_fy, q_fz;

  gn3_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .vld_o    (q_vld),
    .pop_i    (q_pop),
    .ctl_o    (q_ctl),
    .cell_x_o (q_cx),
    .cell_y_o (q_cy),
    .cell_z_o (q_cz),
    .frac_x_o (q_fx),
    .frac_y_o (q_fy),
    .frac_z_o (q_fz)
  );

  gn3_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (q_vld),
    .pop_o    (q_pop),
    .ctl_i    (q_ctl),
    .cell_x_i (q_cx),
    .cell_y_i (q_cy),
    .cell_z_i (q_cz),
    .frac_x_i (q_fx),
    .frac_y_i (q_fy),
    .frac_z_i (q_fz),
    .out_if   (out_if)
  );

endmodule

[src/gn3_checker.sv]
// Port-level checks for the noise unit, bound to the top level.
module gn3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gn3_pkg::OUT_W-1:0]     out_noise
);
  import gn3_pkg::*;

  logic [4:0] pend_q;
  logic       eval_in, res_out;

  assign eval_in = in_valid && in_ready && (in_op == OP_EVAL);
  assign res_out = out_valid && out_ready;

  // Evaluates taken but not yet answered; the pipeline holds at most nine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 5'd0;
    end else begin
      pend_q <= pend_q + 5'(eval_in) - 5'(res_out);
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_noise))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 5'd0)
    else $error("result without a pending evaluate");

endmodule

bind gradient_noise_3d_unit gn3_checker u_gn3_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_op     (in_if.op),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_noise (out_if.noise_value)
);
